@@ src/mcfb_pkg.sv @@
// Shared definitions for the multi-channel bounded FIFO bus.
// Holds default sizes, command and status codes, and the control structs
// passed between the sequencer, the word store and the top level.
`default_nettype none

package mcfb_pkg;

    localparam int NUM_SLOTS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int WORD_WIDTH_DEF  = 32;

    localparam int CMD_W      = 3;
    localparam int SEL_W      = 3;
    localparam int LIMIT_W    = 5;
    localparam int SLOT_OUT_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 3'd0,
        CMD_CLOSE = 3'd1,
        CMD_SEND  = 3'd2,
        CMD_RECV  = 3'd3,
        CMD_BCAST = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_CHAN = 2'd1,
        ST_BLOCK   = 2'd2,
        ST_NO_SLOT = 2'd3
    } status_t;

    // Word store access issued by the sequencer.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } store_ctl_t;

    // Finished result handed from the sequencer to the output register.
    typedef struct packed {
        logic                  valid;
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  word_en;
    } result_t;

endpackage

`default_nettype wire

@@ src/multi_channel_bounded_fifo_bus.sv @@
// Top level of the multi-channel bounded FIFO bus: stream ports and result register.
// Instantiates mcfb_ctrl and mcfb_store; uses mcfb_pkg.
//
// Usage: each request on the s_ channel carries one command in s_tuser (open, close,
// try send, try receive, broadcast) with its operands in s_tdata. Every request gives
// exactly one result on the m_ channel: a status in m_tuser, and in m_tdata the word
// taken by a successful receive and the slot given by a successful open (both zero
// otherwise). Requests are handled one at a time.
// For every request except a broadcast that goes ahead, the slot metadata is read on
// the accept edge, the next cycle does the read-modify-write, the cycle after hands
// the result to the output register as soon as that register is free, and s_tready
// is high again before the next accept. A broadcast that goes ahead sweeps the
// metadata memory one slot per cycle before its result is handed on. A received word
// comes from the word store in the cycle after its read, in the result cycle.
// Reset (aresetn low, synchronous) closes every slot and empties the output
// register; no memory needs a clearing pass, so requests are taken right after.
// When the receiver stalls, the finished result waits in the output register and
// the sequencer holds the following one; s_tready stays low until it moves on.
`default_nettype none

module multi_channel_bounded_fifo_bus #(
    parameter int NUM_SLOTS   = mcfb_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mcfb_pkg::QUEUE_DEPTH_DEF,
    parameter int WORD_WIDTH  = mcfb_pkg::WORD_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0: chan_sel[2:0], send_word[WORD_WIDTH-1:0], open_limit[4:0]
    input  logic [((WORD_WIDTH+8+7)/8)*8-1:0]    s_tdata,
    // s_tuser: cmd[2:0]
    input  logic [mcfb_pkg::CMD_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // m_tdata from bit 0: recv_word[WORD_WIDTH-1:0], opened_slot[2:0]
    output logic [((WORD_WIDTH+3+7)/8)*8-1:0]    m_tdata,
    // m_tuser: status[1:0]
    output logic [1:0]                           m_tuser
);

    localparam int AW        = (NUM_SLOTS*QUEUE_DEPTH > 1) ?
                               $clog2(NUM_SLOTS*QUEUE_DEPTH) : 1;
    localparam int M_TDATA_W = ((WORD_WIDTH + 3 + 7) / 8) * 8;

    logic [mcfb_pkg::SEL_W-1:0]   chan_sel;
    logic [WORD_WIDTH-1:0]        send_word;
    logic [mcfb_pkg::LIMIT_W-1:0] open_limit;

    mcfb_pkg::result_t    res;
    logic                 out_free;
    mcfb_pkg::store_ctl_t store_ctl;
    logic [AW-1:0]        store_addr;
    logic [WORD_WIDTH-1:0] store_wdata;
    logic [WORD_WIDTH-1:0] rd_data;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;

    assign chan_sel   = s_tdata[2:0];
    assign send_word  = s_tdata[WORD_WIDTH+2:3];
    assign open_limit = s_tdata[WORD_WIDTH+7:WORD_WIDTH+3];

    // The output register can take a result when empty or draining this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    mcfb_ctrl #(
        .NUM_SLOTS   (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_sel      (chan_sel),
        .in_word     (send_word),
        .in_limit    (open_limit),
        .res         (res),
        .res_ready   (out_free),
        .store_ctl   (store_ctl),
        .store_addr  (store_addr),
        .store_wdata (store_wdata)
    );

    mcfb_store #(
        .NUM_SLOTS   (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .ctl     (store_ctl),
        .addr    (store_addr),
        .wr_data (store_wdata),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res.valid && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // The received word is only passed on for a successful receive.
    always_ff @(posedge aclk) begin
        if (res.valid && out_free) begin
            m_tdata_reg <= M_TDATA_W'({res.slot,
                                       (res.word_en ? rd_data : WORD_WIDTH'(0))});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Requests are handled strictly one at a time.
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another one is in progress");

    // A pending result blocks new requests.
    a_result_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> !s_tready)
        else $error("input ready while a result is pending");

    // Failed requests carry no word and no slot.
    a_fail_clears_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != mcfb_pkg::ST_OK)) |-> (m_tdata == '0))
        else $error("non-zero result data on a failed request");

endmodule

`default_nettype wire

@@ src/mcfb_store.sv @@
// Word store of the multi-channel bounded FIFO bus: one region per slot.
// Single-port synchronous memory with registered read data; uses mcfb_pkg.
`default_nettype none

module mcfb_store #(
    parameter int NUM_SLOTS   = mcfb_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mcfb_pkg::QUEUE_DEPTH_DEF,
    parameter int WORD_WIDTH  = mcfb_pkg::WORD_WIDTH_DEF
) (
    input  logic                        aclk,
    input  mcfb_pkg::store_ctl_t        ctl,
    input  logic [((NUM_SLOTS*QUEUE_DEPTH > 1) ?
                   $clog2(NUM_SLOTS*QUEUE_DEPTH) : 1)-1:0] addr,
    input  logic [WORD_WIDTH-1:0]       wr_data,
    output logic [WORD_WIDTH-1:0]       rd_data
);

    logic [WORD_WIDTH-1:0] mem [NUM_SLOTS*QUEUE_DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/mcfb_ctrl.sv @@
// Command sequencer of the multi-channel bounded FIFO bus.
// Keeps per-slot limit, count and head in a small synchronous memory, plus open
// and full flags in flops; drives the word store (mcfb_store). Uses mcfb_pkg.
`default_nettype none

module mcfb_ctrl #(
    parameter int NUM_SLOTS   = mcfb_pkg::NUM_SLOTS_DEF,
    parameter int QUEUE_DEPTH = mcfb_pkg::QUEUE_DEPTH_DEF,
    parameter int WORD_WIDTH  = mcfb_pkg::WORD_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mcfb_pkg::CMD_W-1:0]     in_cmd,
    input  logic [mcfb_pkg::SEL_W-1:0]     in_sel,
    input  logic [WORD_WIDTH-1:0]          in_word,
    input  logic [mcfb_pkg::LIMIT_W-1:0]   in_limit,
    output mcfb_pkg::result_t              res,
    input  logic                           res_ready,
    output mcfb_pkg::store_ctl_t           store_ctl,
    output logic [((NUM_SLOTS*QUEUE_DEPTH > 1) ?
                   $clog2(NUM_SLOTS*QUEUE_DEPTH) : 1)-1:0] store_addr,
    output logic [WORD_WIDTH-1:0]          store_wdata
);

    localparam int SW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW  = $clog2(QUEUE_DEPTH + 1);
    localparam int HW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PSW = ((HW > LW) ? HW : LW) + 1;
    localparam int AW  = (NUM_SLOTS*QUEUE_DEPTH > 1) ? $clog2(NUM_SLOTS*QUEUE_DEPTH) : 1;
    localparam int MW  = 2*LW + HW;
    localparam int IW  = SW + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_BCAST = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    mcfb_pkg::cmd_t        cmd_reg, cmd_next;
    logic [SW-1:0]         sel_reg, sel_next;
    logic                  sel_ok_reg, sel_ok_next;
    logic [WORD_WIDTH-1:0] word_reg, word_next;
    logic [LW-1:0]         lim_reg, lim_next;
    mcfb_pkg::status_t     status_reg, status_next;
    logic [SW-1:0]         slot_reg, slot_next;
    logic                  word_en_reg, word_en_next;
    logic [NUM_SLOTS-1:0]  open_reg, open_next;
    logic [NUM_SLOTS-1:0]  full_reg, full_next;
    logic [IW-1:0]         bc_rd_reg, bc_rd_next;
    logic [SW-1:0]         bc_wr_reg, bc_wr_next;
    logic                  bc_pend_reg, bc_pend_next;

    // Slot metadata memory: {limit, count, head}.
    logic [MW-1:0] meta_mem [NUM_SLOTS];
    logic [MW-1:0] meta_q;
    logic          meta_rd_en;
    logic [SW-1:0] meta_rd_addr;
    logic          meta_we;
    logic [SW-1:0] meta_wr_addr;
    logic [MW-1:0] meta_wr_data;

    logic [LW-1:0] m_lim;
    logic [LW-1:0] m_cnt;
    logic [HW-1:0] m_head;
    logic          m_full;
    logic          usable;
    logic          free_any;
    logic [SW-1:0] free_idx;

    function automatic logic [HW-1:0] tail_pos(input logic [HW-1:0] head,
                                               input logic [LW-1:0] cnt);
        logic [PSW-1:0] sum;
        sum = PSW'(head) + PSW'(cnt);
        if (32'(sum) >= QUEUE_DEPTH) begin
            sum = sum - PSW'(QUEUE_DEPTH);
        end
        return HW'(sum);
    endfunction

    function automatic logic [AW-1:0] word_addr(input logic [SW-1:0] slot,
                                                input logic [HW-1:0] pos);
        return AW'(slot) * AW'(QUEUE_DEPTH) + AW'(pos);
    endfunction

    function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] head);
        return (32'(head) == QUEUE_DEPTH - 1) ? HW'(0) : head + HW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_wr_addr] <= meta_wr_data;
        end
        if (meta_rd_en) begin
            meta_q <= meta_mem[meta_rd_addr];
        end
    end

    assign m_lim  = meta_q[MW-1 -: LW];
    assign m_cnt  = meta_q[HW+LW-1 -: LW];
    assign m_head = meta_q[HW-1:0];
    assign m_full = (m_cnt >= m_lim);
    assign usable = sel_ok_reg && open_reg[sel_reg];

    // Lowest closed slot.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!open_reg[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        sel_next     = sel_reg;
        sel_ok_next  = sel_ok_reg;
        word_next    = word_reg;
        lim_next     = lim_reg;
        status_next  = status_reg;
        slot_next    = slot_reg;
        word_en_next = word_en_reg;
        open_next    = open_reg;
        full_next    = full_reg;
        bc_rd_next   = bc_rd_reg;
        bc_wr_next   = bc_wr_reg;
        bc_pend_next = bc_pend_reg;
        meta_rd_en   = 1'b0;
        meta_rd_addr = SW'(in_sel);
        meta_we      = 1'b0;
        meta_wr_addr = sel_reg;
        meta_wr_data = {m_lim, m_cnt, m_head};
        store_ctl    = '0;
        store_addr   = '0;
        store_wdata  = word_reg;
        in_ready     = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE: begin
                // The metadata of the addressed slot is fetched on the accept edge.
                meta_rd_en = 1'b1;
                if (in_valid) begin
                    cmd_next    = mcfb_pkg::cmd_t'(in_cmd);
                    sel_next    = SW'(in_sel);
                    sel_ok_next = (32'(in_sel) < NUM_SLOTS);
                    word_next   = in_word;
                    lim_next    = (32'(in_limit) > QUEUE_DEPTH) ? LW'(QUEUE_DEPTH)
                                                                : LW'(in_limit);
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                status_next  = mcfb_pkg::ST_NO_CHAN;
                slot_next    = '0;
                word_en_next = 1'b0;
                state_next   = S_DONE;
                case (cmd_reg)
                    mcfb_pkg::CMD_OPEN: begin
                        status_next = mcfb_pkg::ST_NO_SLOT;
                        if (free_any) begin
                            open_next[free_idx] = 1'b1;
                            full_next[free_idx] = (lim_reg == '0);
                            meta_we      = 1'b1;
                            meta_wr_addr = free_idx;
                            meta_wr_data = {lim_reg, LW'(0), HW'(0)};
                            slot_next    = free_idx;
                            status_next  = mcfb_pkg::ST_OK;
                        end
                    end
                    mcfb_pkg::CMD_CLOSE: begin
                        // Contents are dropped; the next open rewrites the metadata.
                        if (usable) begin
                            open_next[sel_reg] = 1'b0;
                            status_next        = mcfb_pkg::ST_OK;
                        end
                    end
                    mcfb_pkg::CMD_SEND: begin
                        if (usable) begin
                            if (m_full) begin
                                status_next = mcfb_pkg::ST_BLOCK;
                            end else begin
                                store_ctl.wr_en    = 1'b1;
                                store_addr         = word_addr(sel_reg,
                                                               tail_pos(m_head, m_cnt));
                                meta_we            = 1'b1;
                                meta_wr_data       = {m_lim, m_cnt + LW'(1), m_head};
                                full_next[sel_reg] = ((m_cnt + LW'(1)) >= m_lim);
                                status_next        = mcfb_pkg::ST_OK;
                            end
                        end
                    end
                    mcfb_pkg::CMD_RECV: begin
                        if (usable) begin
                            if (m_cnt == '0) begin
                                status_next = mcfb_pkg::ST_BLOCK;
                            end else begin
                                store_ctl.rd_en    = 1'b1;
                                store_addr         = word_addr(sel_reg, m_head);
                                meta_we            = 1'b1;
                                meta_wr_data       = {m_lim, m_cnt - LW'(1),
                                                      head_inc(m_head)};
                                full_next[sel_reg] = 1'b0;
                                word_en_next       = 1'b1;
                                status_next        = mcfb_pkg::ST_OK;
                            end
                        end
                    end
                    mcfb_pkg::CMD_BCAST: begin
                        if (open_reg == '0) begin
                            status_next = mcfb_pkg::ST_NO_CHAN;
                        end else if (|(open_reg & full_reg)) begin
                            status_next = mcfb_pkg::ST_BLOCK;
                        end else begin
                            bc_rd_next   = '0;
                            bc_pend_next = 1'b0;
                            state_next   = S_BCAST;
                        end
                    end
                    default: begin
                        status_next = mcfb_pkg::ST_NO_CHAN;
                    end
                endcase
            end
            S_BCAST: begin
                // Read slot k while slot k-1 is written back; addresses never meet.
                if (32'(bc_rd_reg) < NUM_SLOTS) begin
                    meta_rd_en   = 1'b1;
                    meta_rd_addr = bc_rd_reg[SW-1:0];
                    bc_rd_next   = bc_rd_reg + IW'(1);
                    bc_wr_next   = bc_rd_reg[SW-1:0];
                    bc_pend_next = 1'b1;
                end else begin
                    bc_pend_next = 1'b0;
                end
                if (bc_pend_reg && open_reg[bc_wr_reg]) begin
                    store_ctl.wr_en      = 1'b1;
                    store_addr           = word_addr(bc_wr_reg, tail_pos(m_head, m_cnt));
                    meta_we              = 1'b1;
                    meta_wr_addr         = bc_wr_reg;
                    meta_wr_data         = {m_lim, m_cnt + LW'(1), m_head};
                    full_next[bc_wr_reg] = ((m_cnt + LW'(1)) >= m_lim);
                end
                if (bc_pend_reg && (32'(bc_rd_reg) >= NUM_SLOTS)) begin
                    status_next = mcfb_pkg::ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            open_reg    <= '0;
            full_reg    <= '0;
            bc_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            full_reg    <= full_next;
            bc_pend_reg <= bc_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        sel_reg     <= sel_next;
        sel_ok_reg  <= sel_ok_next;
        word_reg    <= word_next;
        lim_reg     <= lim_next;
        status_reg  <= status_next;
        slot_reg    <= slot_next;
        word_en_reg <= word_en_next;
        bc_rd_reg   <= bc_rd_next;
        bc_wr_reg   <= bc_wr_next;
    end

    assign res.valid   = (state_reg == S_DONE);
    assign res.status  = status_reg;
    assign res.slot    = mcfb_pkg::SLOT_OUT_W'(slot_reg);
    assign res.word_en = word_en_reg;

endmodule

`default_nettype wire
